[rtl/amm_pkg.sv]
package amm_pkg;

	// configuration register widths and reset values
	localparam int MAP_W     = 24;
	localparam int DZ_W      = 16;
	localparam int GAIN_W    = 16;
	localparam int EN_W      = 3;
	localparam int REG_IDX_W = 2;

	localparam logic [MAP_W-1:0]  MAP_RESET  = 24'h326401;
	localparam logic [DZ_W-1:0]   DZ_RESET   = 16'd6554;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd19661;
	localparam logic [EN_W-1:0]   EN_RESET   = 3'b111;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TARGET_MAP = 2'd0,
		REG_DEADZONE   = 2'd1,
		REG_GAIN       = 2'd2,
		REG_ENABLES    = 2'd3
	} reg_index_t;

	// output enable bit positions
	localparam int EN_BEND  = 0;
	localparam int EN_CC    = 1;
	localparam int EN_LEVEL = 2;

	// result field widths
	localparam int KIND_W     = 2;
	localparam int CC_W       = 7;
	localparam int VAL_W      = 14;
	localparam int TGT_W      = 4;
	localparam int LVL_W      = 16;
	localparam int OUT_DATA_W = ((CC_W + VAL_W + TGT_W + LVL_W + 7) / 8) * 8;
	localparam int PAD_W      = OUT_DATA_W - CC_W - VAL_W - TGT_W - LVL_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_BEND  = 2'd0,
		KIND_CC    = 2'd1,
		KIND_LEVEL = 2'd2
	} kind_t;

	// target codes
	localparam logic [TGT_W-1:0] TGT_NONE       = 4'd0;
	localparam logic [TGT_W-1:0] TGT_BEND       = 4'd1;
	localparam logic [TGT_W-1:0] TGT_MODWHEEL   = 4'd2;
	localparam logic [TGT_W-1:0] TGT_EXPRESSION = 4'd3;
	localparam logic [TGT_W-1:0] TGT_FX_CUTOFF  = 4'd4;
	localparam logic [TGT_W-1:0] TGT_FX_RESO    = 4'd5;
	localparam logic [TGT_W-1:0] TGT_FX_REVERB  = 4'd6;
	localparam logic [TGT_W-1:0] TGT_FX_CHORUS  = 4'd7;
	localparam logic [TGT_W-1:0] TGT_FX_EFFECT  = 4'd8;
	localparam logic [TGT_W-1:0] TGT_FX_VOLUME  = 4'd9;

	// axis numbering
	localparam logic [2:0] MAP_AXES   = 3'd6;
	localparam logic [2:0] STICK_AXES = 3'd4;
	localparam logic [2:0] AXIS_RY    = 3'd3;

	// value ranges
	localparam logic [VAL_W-1:0] BEND_MAX = 14'd16383;
	localparam logic [CC_W-1:0]  CC_MAX   = 7'd127;
	localparam logic [LVL_W-1:0] LVL_MAX  = 16'hffff;

	// scaling shifts: x*8191 = (x << 13) - x and so on
	localparam int BEND_SH  = 13;
	localparam int CCB_SH   = 6;
	localparam int CCU_SH   = 7;
	localparam int LVLB_SH  = 16;
	localparam int LVLU_SH  = 17;

	// deadzone divider and smoothing multiplier
	localparam int DZ_SH      = 17;
	localparam int REM_W      = 17;
	localparam int DVS_W      = 18;
	localparam logic [REM_W-1:0] DZ_FULL = 17'h10000;
	localparam int MUL_DIGITS = GAIN_W / 2;
	localparam int ROUND_SH   = 16;
	localparam int ROUND_HALF = 32768;

	function automatic logic [CC_W-1:0] cc_number(input logic [TGT_W-1:0] tgt);
		logic [CC_W-1:0] cc;
		unique case (tgt)
			TGT_MODWHEEL:   cc = 7'd1;
			TGT_EXPRESSION: cc = 7'd11;
			TGT_FX_CUTOFF:  cc = 7'd74;
			TGT_FX_RESO:    cc = 7'd71;
			TGT_FX_REVERB:  cc = 7'd91;
			TGT_FX_CHORUS:  cc = 7'd93;
			TGT_FX_EFFECT:  cc = 7'd12;
			TGT_FX_VOLUME:  cc = 7'd7;
			default:        cc = '0;
		endcase
		return cc;
	endfunction

endpackage

[rtl/axis_modulation_mapper_top.sv]
// Axis modulation mapper: takes one controller axis sample per input transfer
// (axis number and a signed Q1.(SAMPLE_BITS-1) position), inverts right-stick Y
// with saturation, applies a rescaled deadzone to the four stick axes, keeps a
// per-axis exponential average and turns it into pitch bend, control change and
// parameter level results as chosen by the per-axis target map. Bend and control
// change results go out only when their value changes; a parameter level goes out
// on every update of an effect target. Each input sample is handled one at a time:
// a sample gives up to two results, and the block takes no new sample until the
// last of them is in the output register, which may wait for m_axis_tready. A
// stick sample passes the deadzone divider, which resolves one quotient bit per
// cycle, and the smoothing multiplier, which consumes two gain bits per cycle. A
// stick sample inside the deadzone skips the divider; a trigger sample skips both
// the deadzone and the divider. Samples for an axis with target none, or beyond
// AXIS_COUNT, are accepted and produce nothing. The last result of a sample waits
// in the output register while the next sample is taken. Configuration writes are
// always accepted and should be made while the block is idle.
module axis_modulation_mapper_top
	import amm_pkg::*;
#(
	parameter int AXIS_COUNT  = 6,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,

	// configuration write channel
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [REG_IDX_W-1:0]                      cfg_index,
	input  logic [MAP_W-1:0]                          cfg_data,

	// sample input: tdata = axis[2:0], sample[SAMPLE_BITS+2:3], zero fill
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  logic [((SAMPLE_BITS + 3 + 7) / 8) * 8-1:0] s_axis_tdata,

	// result output: tdata = controller, value, param_target, param_level, zero fill
	// tuser = kind; tlast marks the final result of a sample
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	output logic [OUT_DATA_W-1:0]                     m_axis_tdata,
	output logic [KIND_W-1:0]                         m_axis_tuser,
	output logic                                      m_axis_tlast
);

	localparam int FRAC  = SAMPLE_BITS - 1;
	localparam int AX_W  = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
	localparam int S_W   = SAMPLE_BITS + 1;   // smoothed level, -1..+1
	localparam int DW    = SAMPLE_BITS + 2;   // target minus smoothed level
	localparam int PW    = SAMPLE_BITS + 18;  // gain times difference
	localparam int EW    = SAMPLE_BITS + 18;  // scaling of the smoothed level
	localparam int NW    = SAMPLE_BITS + 17;  // deadzone numerator
	localparam int CNT_W = $clog2(SAMPLE_BITS);

	localparam logic [EW-1:0] ONE_W = {{(EW - 1){1'b0}}, 1'b1} << FRAC;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DZ,
		ST_DIV,
		ST_DIFF,
		ST_TRIPLE,
		ST_MUL,
		ST_UPD,
		ST_EVAL,
		ST_SEND,
		ST_EMIT1,
		ST_EMIT2
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;

	// configuration
	logic [MAP_W-1:0]  map_q;
	logic [DZ_W-1:0]   dz_q;
	logic [GAIN_W-1:0] gain_q;
	logic [EN_W-1:0]   en_q;

	// per-axis state
	logic signed [S_W-1:0] smooth_q [AXIS_COUNT];
	logic [VAL_W-1:0]      last_val_q [AXIS_COUNT];
	logic [AXIS_COUNT-1:0] last_vld_q;

	// current sample
	logic [2:0]                    axis_q;
	logic [TGT_W-1:0]              tgt_q;
	logic                          bip_q;
	logic signed [SAMPLE_BITS-1:0] x_q;

	// divider: remainder and a shared numerator / quotient shift register
	logic [REM_W-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0] nq_q;
	logic [DVS_W-1:0]       dvs_q;

	// multiplier
	logic signed [DW-1:0]   diff_q;
	logic signed [DW:0]     d3_q;
	logic [GAIN_W-1:0]      mul_q;
	logic signed [PW-1:0]   acc_q;
	logic signed [S_W-1:0]  s_q;

	// results
	logic [VAL_W-1:0] v_q;
	logic [LVL_W-1:0] lvl_q;
	kind_t            res_kind_q;
	logic [CC_W-1:0]  res_cc_q;
	logic             has2_q;

	// output register
	logic             out_vld_q;
	kind_t            out_kind_q;
	logic [CC_W-1:0]  out_cc_q;
	logic [VAL_W-1:0] out_val_q;
	logic [TGT_W-1:0] out_pt_q;
	logic [LVL_W-1:0] out_lvl_q;
	logic             out_last_q;

	logic [AX_W-1:0] ax_idx;
	logic            out_free;

	// input decode
	logic [2:0]                    in_axis;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic signed [SAMPLE_BITS-1:0] in_x;
	logic [TGT_W-1:0]              in_tgt;
	logic                          in_take;

	// deadzone set-up
	logic [SAMPLE_BITS-1:0] dz_mag;
	logic [NW-1:0]          dz_lhs;
	logic [NW-1:0]          dz_rhs;
	logic [NW-1:0]          dz_num;
	logic [DVS_W-1:0]       dz_dvs;

	// divider step
	logic [DVS_W-1:0] trial;
	logic [DVS_W-1:0] trial_sub;
	logic             trial_ge;

	// difference and multiplier step
	logic signed [DW-1:0]  q_w;
	logic signed [DW-1:0]  p_w;
	logic signed [S_W-1:0] s_rd;
	logic signed [DW-1:0]  diff_w;
	logic signed [DW:0]    addend;
	logic signed [PW-1:0]  rnd;
	logic signed [DW-1:0]  s_sum;

	// scaling
	logic signed [EW-1:0] s_w;
	logic signed [EW-1:0] sp_w;
	logic signed [EW-1:0] bend_sh;
	logic signed [EW-1:0] ccb_sh;
	logic signed [EW-1:0] ccu_sh;
	logic signed [EW-1:0] lvlb_sh;
	logic signed [EW-1:0] lvlu_sh;
	logic                 s_pos;
	logic [VAL_W-1:0]     bend_v;
	logic [CC_W-1:0]      ccb_v;
	logic [CC_W-1:0]      ccu_v;
	logic [LVL_W-1:0]     lvlb_v;
	logic [LVL_W-1:0]     lvlu_v;

	// send decision
	logic changed;
	logic send1;
	logic send2;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_lvl_q, out_pt_q, out_val_q, out_cc_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	assign ax_idx   = AX_W'(axis_q);
	assign out_free = !out_vld_q || m_axis_tready;

	// input: right-stick Y is inverted, minus one saturates to the top code
	always_comb begin
		in_axis   = s_axis_tdata[2:0];
		in_sample = $signed(s_axis_tdata[SAMPLE_BITS+2:3]);
		if (in_axis == AXIS_RY) begin
			if (in_sample == $signed({1'b1, {FRAC{1'b0}}}))
				in_x = $signed({1'b0, {FRAC{1'b1}}});
			else
				in_x = -in_sample;
		end else begin
			in_x = in_sample;
		end
		in_tgt  = (in_axis < MAP_AXES) ? map_q[{in_axis, 2'b00} +: TGT_W] : TGT_NONE;
		in_take = (int'(in_axis) < AXIS_COUNT) && (in_tgt != TGT_NONE);
	end

	// deadzone: quotient of (|x| * 2^17 - d * 2^SB) by 2 * (65536 - d)
	always_comb begin
		dz_mag = x_q[SAMPLE_BITS-1] ? $unsigned(-x_q) : $unsigned(x_q);
		dz_lhs = {dz_mag, {DZ_SH{1'b0}}};
		dz_rhs = {1'b0, dz_q, {SAMPLE_BITS{1'b0}}};
		dz_num = dz_lhs - dz_rhs;
		dz_dvs = {DZ_FULL - {1'b0, dz_q}, 1'b0};
	end

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial     = {rem_q, nq_q[SAMPLE_BITS-1]};
		trial_ge  = (trial >= dvs_q);
		trial_sub = trial - dvs_q;
	end

	always_comb begin
		q_w    = $signed({2'b00, nq_q});
		if (bip_q)
			p_w = x_q[SAMPLE_BITS-1] ? -q_w : q_w;
		else
			p_w = DW'(x_q);
		s_rd   = smooth_q[ax_idx];
		diff_w = p_w - DW'(s_rd);

		// radix-4 digit of the gain, most significant first
		unique case (mul_q[GAIN_W-1 -: 2])
			2'd0: addend = '0;
			2'd1: addend = (DW + 1)'(diff_q);
			2'd2: addend = (DW + 1)'(diff_q) <<< 1;
			2'd3: addend = d3_q;
		endcase

		// round to nearest, halves upwards
		rnd   = acc_q + PW'(ROUND_HALF);
		s_sum = DW'(s_q) + $signed(rnd[PW-1:ROUND_SH]);
	end

	// scaling of the smoothed level to bend, control and level codes
	always_comb begin
		s_w     = EW'(s_q);
		sp_w    = s_w + $signed(ONE_W);
		s_pos   = !s_w[EW-1] && (s_w != '0);
		bend_sh = ((sp_w <<< BEND_SH) - s_w) >>> FRAC;
		ccb_sh  = ((sp_w <<< CCB_SH) - s_w) >>> FRAC;
		ccu_sh  = ((s_w <<< CCU_SH) - s_w) >>> FRAC;
		lvlb_sh = (sp_w <<< LVLB_SH) >>> SAMPLE_BITS;
		lvlu_sh = (s_w <<< LVLU_SH) >>> SAMPLE_BITS;

		if (bend_sh[EW-1])
			bend_v = '0;
		else if (bend_sh > EW'(BEND_MAX))
			bend_v = BEND_MAX;
		else
			bend_v = bend_sh[VAL_W-1:0];

		if (ccb_sh[EW-1])
			ccb_v = '0;
		else if (ccb_sh > EW'(CC_MAX))
			ccb_v = CC_MAX;
		else
			ccb_v = ccb_sh[CC_W-1:0];

		if (!s_pos)
			ccu_v = '0;
		else if (ccu_sh > EW'(CC_MAX))
			ccu_v = CC_MAX;
		else
			ccu_v = ccu_sh[CC_W-1:0];

		if (lvlb_sh > EW'(LVL_MAX))
			lvlb_v = LVL_MAX;
		else
			lvlb_v = lvlb_sh[LVL_W-1:0];

		if (!s_pos)
			lvlu_v = '0;
		else if (lvlu_sh > EW'(LVL_MAX))
			lvlu_v = LVL_MAX;
		else
			lvlu_v = lvlu_sh[LVL_W-1:0];
	end

	// bend and control change share one last-sent value per axis
	always_comb begin
		changed = !last_vld_q[ax_idx] || (last_val_q[ax_idx] != v_q);
		send1   = 1'b0;
		send2   = 1'b0;
		if (tgt_q == TGT_BEND) begin
			send1 = en_q[EN_BEND] && changed;
		end else if (tgt_q <= TGT_FX_VOLUME) begin
			send1 = en_q[EN_CC] && changed;
			send2 = (tgt_q >= TGT_FX_CUTOFF) && en_q[EN_LEVEL];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			map_q      <= MAP_RESET;
			dz_q       <= DZ_RESET;
			gain_q     <= GAIN_RESET;
			en_q       <= EN_RESET;
			for (int i = 0; i < AXIS_COUNT; i++) begin
				smooth_q[i]   <= '0;
				last_val_q[i] <= '0;
			end
			last_vld_q <= '0;
			axis_q     <= '0;
			tgt_q      <= TGT_NONE;
			bip_q      <= 1'b0;
			x_q        <= '0;
			rem_q      <= '0;
			nq_q       <= '0;
			dvs_q      <= '0;
			diff_q     <= '0;
			d3_q       <= '0;
			mul_q      <= '0;
			acc_q      <= '0;
			s_q        <= '0;
			v_q        <= '0;
			lvl_q      <= '0;
			res_kind_q <= KIND_BEND;
			res_cc_q   <= '0;
			has2_q     <= 1'b0;
			out_vld_q  <= 1'b0;
			out_kind_q <= KIND_BEND;
			out_cc_q   <= '0;
			out_val_q  <= '0;
			out_pt_q   <= '0;
			out_lvl_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (reg_index_t'(cfg_index))
					REG_TARGET_MAP: map_q  <= cfg_data;
					REG_DEADZONE:   dz_q   <= cfg_data[DZ_W-1:0];
					REG_GAIN:       gain_q <= cfg_data[GAIN_W-1:0];
					REG_ENABLES:    en_q   <= cfg_data[EN_W-1:0];
				endcase
			end

			// the emit states reload the output register themselves
			if (out_vld_q && m_axis_tready && (state_q != ST_EMIT1) && (state_q != ST_EMIT2))
				out_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && in_take) begin
						axis_q  <= in_axis;
						tgt_q   <= in_tgt;
						bip_q   <= (in_axis < STICK_AXES);
						x_q     <= in_x;
						state_q <= (in_axis < STICK_AXES) ? ST_DZ : ST_DIFF;
					end
				end
				ST_DZ: begin
					dvs_q <= dz_dvs;
					cnt_q <= CNT_W'(SAMPLE_BITS - 1);
					if (dz_lhs < dz_rhs) begin
						// inside the deadzone
						nq_q    <= '0;
						state_q <= ST_DIFF;
					end else begin
						rem_q   <= dz_num[NW-1:SAMPLE_BITS];
						nq_q    <= dz_num[SAMPLE_BITS-1:0];
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
					nq_q  <= {nq_q[SAMPLE_BITS-2:0], trial_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					diff_q  <= diff_w;
					s_q     <= s_rd;
					mul_q   <= gain_q;
					acc_q   <= '0;
					state_q <= ST_TRIPLE;
				end
				ST_TRIPLE: begin
					d3_q    <= (DW + 1)'(diff_q) + ((DW + 1)'(diff_q) <<< 1);
					cnt_q   <= CNT_W'(MUL_DIGITS - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q <= (acc_q <<< 2) + PW'(addend);
					mul_q <= mul_q << 2;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					smooth_q[ax_idx] <= s_sum[S_W-1:0];
					s_q              <= s_sum[S_W-1:0];
					state_q          <= ST_EVAL;
				end
				ST_EVAL: begin
					if (tgt_q == TGT_BEND)
						v_q <= bend_v;
					else
						v_q <= VAL_W'(bip_q ? ccb_v : ccu_v);
					lvl_q   <= bip_q ? lvlb_v : lvlu_v;
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					res_kind_q <= (tgt_q == TGT_BEND) ? KIND_BEND : KIND_CC;
					res_cc_q   <= cc_number(tgt_q);
					has2_q     <= send2;
					if (send1) begin
						last_val_q[ax_idx] <= v_q;
						last_vld_q[ax_idx] <= 1'b1;
						state_q            <= ST_EMIT1;
					end else if (send2) begin
						state_q <= ST_EMIT2;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT1: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_kind_q <= res_kind_q;
						out_cc_q   <= res_cc_q;
						out_val_q  <= v_q;
						out_pt_q   <= '0;
						out_lvl_q  <= '0;
						out_last_q <= !has2_q;
						state_q    <= has2_q ? ST_EMIT2 : ST_IDLE;
					end
				end
				ST_EMIT2: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_kind_q <= KIND_LEVEL;
						out_cc_q   <= '0;
						out_val_q  <= '0;
						out_pt_q   <= tgt_q;
						out_lvl_q  <= lvl_q;
						out_last_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
